// ----- rtl/fls_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fls_pkg: shared types and constants for the flux limiter select block
// Field widths, limiter mode codes and the control word passed along the
// divider cell chain.
// ----------------------------------------------------------------------------
package fls_pkg;

    // fixed field widths
    localparam int RATIO_W = 24;  // slope ratio, signed
    localparam int MAG_W   = 23;  // magnitude bits of a positive ratio
    localparam int OUT_W   = 18;  // limiter value, unsigned
    localparam int MODE_W  = 3;   // limiter mode register
    localparam int SQ_W    = 46;  // width of r*r for a positive ratio

    // limiter mode codes
    typedef enum logic [MODE_W-1:0] {
        MODE_NONE       = 3'd0,
        MODE_MINMOD     = 3'd1,
        MODE_VAN_ALBADA = 3'd2,
        MODE_VAN_LEER   = 3'd3,
        MODE_SUPERBEE   = 3'd4
    } t_mode;

    // control word travelling with each item down the cell chain
    typedef struct packed {
        logic valid;    // stage holds an item
        logic use_div;  // result comes from the divider, not the bypass value
    } t_ctl;

endpackage

// ----- rtl/fls_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fls_cell: one restoring division cell
// Compares the partial remainder with the divisor, subtracts when it fits,
// shifts in one quotient bit and hands everything to the next cell.
// ----------------------------------------------------------------------------
module fls_cell
    import fls_pkg::*;
#(
    parameter int DW = 51,  // remainder / divisor width
    parameter int QW = 17,  // quotient width
    parameter int PW = 18   // bypass value width
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_ctl          i_ctl,
    input  logic [DW-1:0] i_rem,
    input  logic [DW-1:0] i_den,
    input  logic [QW-1:0] i_quot,
    input  logic [PW-1:0] i_byp,
    output t_ctl          o_ctl,
    output logic [DW-1:0] o_rem,
    output logic [DW-1:0] o_den,
    output logic [QW-1:0] o_quot,
    output logic [PW-1:0] o_byp
);

    t_ctl          r_ctl;
    logic [DW-1:0] r_rem, n_rem;
    logic [DW-1:0] r_den;
    logic [QW-1:0] r_quot, n_quot;
    logic [PW-1:0] r_byp;
    logic          fits;
    logic [DW-1:0] diff;

    // compare, conditional subtract, shift
    always_comb begin
        fits   = (i_rem >= i_den);
        diff   = fits ? (i_rem - i_den) : i_rem;
        n_rem  = {diff[DW-2:0], 1'b0};
        n_quot = {i_quot[QW-2:0], fits};
    end

    // control register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_den  <= i_den;
        r_quot <= n_quot;
        r_byp  <= i_byp;
    end

    assign o_ctl  = r_ctl;
    assign o_rem  = r_rem;
    assign o_den  = r_den;
    assign o_quot = r_quot;
    assign o_byp  = r_byp;

endmodule

// ----- rtl/flux_limiter_select.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flux_limiter_select: TVD flux limiter (min-mod, van Albada, van Leer,
// superbee)
// Maps a slope ratio to the limiter value phi. Divider-based limiters run
// through a chain of restoring division cells, one quotient bit per cell.
// ----------------------------------------------------------------------------
//  channel   | signals                                 | handshake
//  ----------+-----------------------------------------+----------------------
//  config    | i_cfg_we, i_cfg_data                    | write when i_cfg_we
//  item in   | start, i_slope_ratio, i_ratio_undefined | start && !busy
//  result    | o_strobe, o_limiter_value               | one cycle, o_strobe
//
//  One item per cycle, every cycle; busy is always low.
//  From the accepting edge to the strobe an item passes the input stage
//  with the r*r multiplier, the operand stage, FRAC_BITS + 1 division
//  cells and the output register.
//  Synchronous active-low reset clears the mode register and all valid bits.
//  The receiver cannot stall; results leave on the strobe cycle.
// ----------------------------------------------------------------------------
module flux_limiter_select
    import fls_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [MODE_W-1:0]         i_cfg_data,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [RATIO_W-1:0] i_slope_ratio,
    input  logic                      i_ratio_undefined,
    output logic                      o_strobe,
    output logic [OUT_W-1:0]          o_limiter_value
);

    localparam int N   = FRAC_BITS + 1;        // division cells
    localparam int QW  = FRAC_BITS + 1;        // quotient bits
    localparam int PW  = FRAC_BITS + 2;        // phi width, holds 2.0
    localparam int CW  = (FRAC_BITS + 3 > 25) ? FRAC_BITS + 3 : 25;
    localparam int DW  = ((2 * FRAC_BITS > SQ_W) ? 2 * FRAC_BITS : SQ_W) + 3;
    localparam int LAT = FRAC_BITS + 4;        // assertion offset in edges

    // mode register
    logic [MODE_W-1:0] r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NONE;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_data;
        end
    end

    assign busy = 1'b0;

    // input stage: sign test, bypass limiters, r*r
    logic [CW-1:0] rr, one_c, two_c, r2, mm_v, sb_a, sb_b, sb_v;
    logic          r_pos;
    logic [PW-1:0] n_s1_byp;
    t_ctl          n_s1_ctl;
    logic          n_s1_va;

    always_comb begin
        rr    = CW'(i_slope_ratio[MAG_W-1:0]);
        one_c = CW'(1) << FRAC_BITS;
        two_c = one_c << 1;
        r2    = rr << 1;
        mm_v  = (rr < one_c) ? rr : one_c;
        sb_a  = (r2 < one_c) ? r2 : one_c;
        sb_b  = (rr < two_c) ? rr : two_c;
        sb_v  = (sb_a > sb_b) ? sb_a : sb_b;
        r_pos = !i_slope_ratio[RATIO_W-1] && (i_slope_ratio != '0);

        n_s1_ctl.valid   = start;
        n_s1_ctl.use_div = 1'b0;
        n_s1_va          = (r_mode == MODE_VAN_ALBADA);
        n_s1_byp         = '0;
        if (i_ratio_undefined) begin
            case (r_mode)
                MODE_MINMOD, MODE_VAN_ALBADA: n_s1_byp = PW'(one_c);
                MODE_VAN_LEER, MODE_SUPERBEE: n_s1_byp = PW'(two_c);
                default:                      n_s1_byp = '0;
            endcase
        end else if (r_pos) begin
            case (r_mode)
                MODE_MINMOD:     n_s1_byp = PW'(mm_v);
                MODE_SUPERBEE:   n_s1_byp = PW'(sb_v);
                MODE_VAN_ALBADA,
                MODE_VAN_LEER:   n_s1_ctl.use_div = 1'b1;
                default:         n_s1_byp = '0;
            endcase
        end
    end

    t_ctl             r_s1_ctl;
    logic [SQ_W-1:0]  r_s1_sq;
    logic [MAG_W-1:0] r_s1_r;
    logic             r_s1_va;
    logic [PW-1:0]    r_s1_byp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
        end else begin
            r_s1_ctl <= n_s1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_sq  <= SQ_W'(i_slope_ratio[MAG_W-1:0]) * SQ_W'(i_slope_ratio[MAG_W-1:0]);
        r_s1_r   <= i_slope_ratio[MAG_W-1:0];
        r_s1_va  <= n_s1_va;
        r_s1_byp <= n_s1_byp;
    end

    // operand stage: dividend and divisor for van Albada or van Leer
    logic [DW-1:0] n_h_num, n_h_den, rx, sqx;

    always_comb begin
        rx  = DW'(r_s1_r);
        sqx = DW'(r_s1_sq);
        if (r_s1_va) begin
            n_h_num = sqx + (rx << FRAC_BITS);
            n_h_den = sqx + (DW'(1) << (2 * FRAC_BITS));
        end else begin
            n_h_num = rx << 1;
            n_h_den = rx + (DW'(1) << FRAC_BITS);
        end
    end

    t_ctl          r_h_ctl;
    logic [DW-1:0] r_h_num, r_h_den;
    logic [PW-1:0] r_h_byp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_ctl <= '0;
        end else begin
            r_h_ctl <= r_s1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h_num <= n_h_num;
        r_h_den <= n_h_den;
        r_h_byp <= r_s1_byp;
    end

    // division cell chain: integer bit first, then FRAC_BITS fraction bits
    t_ctl          c_ctl  [0:N];
    logic [DW-1:0] c_rem  [0:N];
    logic [DW-1:0] c_den  [0:N];
    logic [QW-1:0] c_quot [0:N];
    logic [PW-1:0] c_byp  [0:N];

    assign c_ctl[0]  = r_h_ctl;
    assign c_rem[0]  = r_h_num;
    assign c_den[0]  = r_h_den;
    assign c_quot[0] = '0;
    assign c_byp[0]  = r_h_byp;

    for (genvar g = 0; g < N; g++) begin : g_cell
        fls_cell #(
            .DW (DW),
            .QW (QW),
            .PW (PW)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (c_ctl[g]),
            .i_rem  (c_rem[g]),
            .i_den  (c_den[g]),
            .i_quot (c_quot[g]),
            .i_byp  (c_byp[g]),
            .o_ctl  (c_ctl[g+1]),
            .o_rem  (c_rem[g+1]),
            .o_den  (c_den[g+1]),
            .o_quot (c_quot[g+1]),
            .o_byp  (c_byp[g+1])
        );
    end

    // output register: pick quotient or bypass, fit to the output field
    logic [PW-1:0]       phi;
    logic [PW+OUT_W-1:0] phi_wide;
    logic                r_out_valid;
    logic [OUT_W-1:0]    r_out_val;

    always_comb begin
        phi      = c_ctl[N].use_div ? PW'(c_quot[N]) : c_byp[N];
        phi_wide = (PW + OUT_W)'(phi);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= c_ctl[N].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_val <= phi_wide[OUT_W-1:0];
    end

    assign o_strobe        = r_out_valid;
    assign o_limiter_value = r_out_val;

    // assertions
    localparam logic [PW+OUT_W-1:0] TWO_WIDE = (PW + OUT_W)'(1) << (FRAC_BITS + 1);

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##LAT o_strobe)
        else $error("accepted item did not produce a result on time");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, LAT))
        else $error("result strobe without an accepted item");

    a_nonpos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(start && !i_ratio_undefined
            && (i_slope_ratio[RATIO_W-1] || (i_slope_ratio == '0)), LAT))
        |-> (o_limiter_value == '0))
        else $error("non-positive ratio gave a nonzero limiter value");

    a_undef_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(start && i_ratio_undefined
            && ((r_mode == MODE_VAN_LEER) || (r_mode == MODE_SUPERBEE)), LAT))
        |-> (o_limiter_value == TWO_WIDE[OUT_W-1:0]))
        else $error("undefined ratio in van Leer or superbee did not give two");

endmodule
